FILE: sv/lcal_pkg.sv
// Shared types, constants and helper functions of the binary lifting ancestor engine.
package lcal_pkg;

	localparam int NODES   = 1024;
	localparam int LEVELS  = 10;

	localparam int MODE_W  = 2;
	localparam int NODE_W  = 10;
	localparam int ID_W    = 11;
	localparam int DEPTH_W = 10;
	localparam int COUNT_W = 10;
	localparam int WIDE_W  = 17;
	localparam int IDX_W   = $clog2(NODES);
	localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [ID_W-1:0]    id_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [WIDE_W-1:0]  wide_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [LVL_W-1:0]   lvl_t;
	typedef logic [LEVELS-1:0]  bank_mask_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD  = 2'd0,
		MODE_BUILD = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	localparam id_t    NONE_ID     = 11'h7FF;
	localparam count_t COUNT_RESET = 10'd1023;
	localparam lvl_t   LVL_TOP     = lvl_t'(LEVELS - 1);
	localparam idx_t   IDX_LAST    = idx_t'(NODES - 1);

	// Datapath commands issued by the controller, one per cycle.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_CAPTURE,
		OP_LOAD,
		OP_BUILD_INIT,
		OP_BUILD_READ,
		OP_BUILD_FOLLOW,
		OP_BUILD_WRITE,
		OP_DEPTH_READ,
		OP_ORDER,
		OP_LIFT_STEP,
		OP_LIFT_TAKE,
		OP_JUMP_INIT,
		OP_JUMP_READ,
		OP_JUMP_TAKE,
		OP_PARENT_READ,
		OP_PARENT_TAKE,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		mode_t mode;
		logic  clear_last;
		logic  build_empty;
		logic  build_last;
		logic  diff_zero;
		logic  diff_bit;
		logic  u_eq_v;
		logic  lvl_zero;
		logic  out_free;
	} dp_status_t;

	// Depth difference bits at or above LEVELS take no part in the lift.
	function automatic depth_t diff_mask();
		depth_t m;
		for (int i = 0; i < DEPTH_W; i++) begin
			m[i] = (i < LEVELS);
		end
		return m;
	endfunction

	localparam depth_t DIFF_MASK = diff_mask();

	function automatic logic is_node(id_t id);
		return (id != NONE_ID) && (wide_t'(id) < wide_t'(NODES));
	endfunction

	function automatic idx_t idx_of(id_t id);
		wide_t w;
		w = wide_t'(id);
		return w[IDX_W-1:0];
	endfunction

endpackage

FILE: sv/lcal_intf.sv
// Valid/ready channel interfaces for items and results.
interface lcal_in_if;
	logic                  valid;
	logic                  ready;
	logic [1:0]            mode;
	lcal_pkg::node_t       node;
	lcal_pkg::node_t       other_node;
	lcal_pkg::id_t         parent_node;
	lcal_pkg::depth_t      depth_value;

	modport source (output valid, mode, node, other_node, parent_node, depth_value,
		input ready);
	modport sink (input valid, mode, node, other_node, parent_node, depth_value,
		output ready);
endinterface

interface lcal_out_if;
	logic            valid;
	logic            ready;
	lcal_pkg::id_t   ancestor;
	logic            ancestor_valid;

	modport source (output valid, ancestor, ancestor_valid, input ready);
	modport sink (input valid, ancestor, ancestor_valid, output ready);
endinterface

FILE: sv/lcal_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module lcal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

FILE: sv/lcal_ctrl.sv
// Controller state machine: sequences clear, load, build and query over the datapath.
module lcal_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lcal_pkg::dp_status_t status,
	output lcal_pkg::dp_op_t     op
);

	typedef enum logic [14:0] {
		S_CLEAR    = 15'h0001,
		S_IDLE     = 15'h0002,
		S_DISPATCH = 15'h0004,
		S_B_RD     = 15'h0008,
		S_B_MID    = 15'h0010,
		S_B_WR     = 15'h0020,
		S_Q_ORDER  = 15'h0040,
		S_Q_LIFT   = 15'h0080,
		S_Q_LTAKE  = 15'h0100,
		S_Q_CMP    = 15'h0200,
		S_Q_JUMP   = 15'h0400,
		S_Q_JTAKE  = 15'h0800,
		S_Q_PARENT = 15'h1000,
		S_Q_ANS    = 15'h2000,
		S_DONE     = 15'h4000
	} state_t;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		op         = lcal_pkg::OP_NONE;
		in_ready   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				op = lcal_pkg::OP_CLEAR;
				if (status.clear_last) begin
					state_next = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op         = lcal_pkg::OP_CAPTURE;
					state_next = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				unique case (status.mode)
					lcal_pkg::MODE_LOAD: begin
						op         = lcal_pkg::OP_LOAD;
						state_next = S_DONE;
					end
					lcal_pkg::MODE_BUILD: begin
						if (status.build_empty) begin
							state_next = S_DONE;
						end else begin
							op         = lcal_pkg::OP_BUILD_INIT;
							state_next = S_B_RD;
						end
					end
					lcal_pkg::MODE_QUERY: begin
						op         = lcal_pkg::OP_DEPTH_READ;
						state_next = S_Q_ORDER;
					end
					default: begin
						state_next = S_DONE;
					end
				endcase
			end
			S_B_RD: begin
				op         = lcal_pkg::OP_BUILD_READ;
				state_next = S_B_MID;
			end
			S_B_MID: begin
				op         = lcal_pkg::OP_BUILD_FOLLOW;
				state_next = S_B_WR;
			end
			S_B_WR: begin
				op         = lcal_pkg::OP_BUILD_WRITE;
				state_next = status.build_last ? S_DONE : S_B_RD;
			end
			S_Q_ORDER: begin
				op         = lcal_pkg::OP_ORDER;
				state_next = S_Q_LIFT;
			end
			S_Q_LIFT: begin
				// stop as soon as no depth difference bits remain
				if (status.diff_zero) begin
					state_next = S_Q_CMP;
				end else begin
					op = lcal_pkg::OP_LIFT_STEP;
					if (status.diff_bit) begin
						state_next = S_Q_LTAKE;
					end
				end
			end
			S_Q_LTAKE: begin
				op         = lcal_pkg::OP_LIFT_TAKE;
				state_next = S_Q_LIFT;
			end
			S_Q_CMP: begin
				op         = lcal_pkg::OP_JUMP_INIT;
				state_next = status.u_eq_v ? S_DONE : S_Q_JUMP;
			end
			S_Q_JUMP: begin
				op         = lcal_pkg::OP_JUMP_READ;
				state_next = S_Q_JTAKE;
			end
			S_Q_JTAKE: begin
				op         = lcal_pkg::OP_JUMP_TAKE;
				state_next = status.lvl_zero ? S_Q_PARENT : S_Q_JUMP;
			end
			S_Q_PARENT: begin
				op         = lcal_pkg::OP_PARENT_READ;
				state_next = S_Q_ANS;
			end
			S_Q_ANS: begin
				op         = lcal_pkg::OP_PARENT_TAKE;
				state_next = S_DONE;
			end
			S_DONE: begin
				if (status.out_free) begin
					op         = lcal_pkg::OP_EMIT;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/lcal_datapath.sv
// Datapath: ancestor table banks, depth memory, lift registers and the result register.
module lcal_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcal_pkg::dp_op_t     op,
	output lcal_pkg::dp_status_t status,
	input  logic                 cfg_we,
	input  lcal_pkg::count_t     cfg_wdata,
	input  logic [1:0]           in_mode,
	input  lcal_pkg::node_t      in_node,
	input  lcal_pkg::node_t      in_other_node,
	input  lcal_pkg::id_t        in_parent_node,
	input  lcal_pkg::depth_t     in_depth_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lcal_pkg::id_t        out_ancestor,
	output logic                 out_ancestor_valid
);

	lcal_pkg::count_t node_count_q;
	lcal_pkg::idx_t   idx_q;
	logic             out_valid_q;

	lcal_pkg::mode_t  mode_q;
	lcal_pkg::node_t  node_q;
	lcal_pkg::node_t  other_q;
	lcal_pkg::id_t    parent_q;
	lcal_pkg::depth_t depth_q;
	lcal_pkg::lvl_t   lvl_q;
	lcal_pkg::depth_t diff_q;
	lcal_pkg::id_t    u_q;
	lcal_pkg::id_t    v_q;
	lcal_pkg::id_t    mid_q;
	lcal_pkg::id_t    res_q;
	lcal_pkg::id_t    out_ancestor_q;
	logic             out_ancestor_valid_q;

	lcal_pkg::bank_mask_t tab_we;
	lcal_pkg::idx_t       tab_waddr;
	lcal_pkg::id_t        tab_wdata;
	lcal_pkg::idx_t       tab_raddr_a;
	lcal_pkg::idx_t       tab_raddr_b;
	lcal_pkg::id_t        tab_rd_a [lcal_pkg::LEVELS];
	lcal_pkg::id_t        tab_rd_b [lcal_pkg::LEVELS];

	logic             dep_we;
	lcal_pkg::idx_t   dep_raddr_b;
	lcal_pkg::depth_t dep_rd_a;
	lcal_pkg::depth_t dep_rd_b;

	lcal_pkg::id_t    node_id;
	lcal_pkg::id_t    other_id;
	lcal_pkg::idx_t   node_idx;
	logic             node_ok;
	logic             other_ok;
	lcal_pkg::lvl_t   lvl_src;
	lcal_pkg::id_t    rd_src;
	lcal_pkg::id_t    rd_a_lvl;
	lcal_pkg::id_t    rd_b_lvl;
	lcal_pkg::wide_t  count_w;
	lcal_pkg::wide_t  last_w;
	lcal_pkg::idx_t   last_idx;
	lcal_pkg::depth_t du;
	lcal_pkg::depth_t dv;
	logic             swap;
	lcal_pkg::id_t    jump_a;
	lcal_pkg::id_t    jump_b;

	assign node_id  = lcal_pkg::id_t'(node_q);
	assign other_id = lcal_pkg::id_t'(other_q);
	assign node_idx = lcal_pkg::idx_of(node_id);
	assign node_ok  = lcal_pkg::is_node(node_id);
	assign other_ok = lcal_pkg::is_node(other_id);

	// build reads level lvl-1 and writes level lvl
	assign lvl_src  = lvl_q - lcal_pkg::lvl_t'(1);
	assign rd_src   = tab_rd_a[lvl_src];
	assign rd_a_lvl = tab_rd_a[lvl_q];
	assign rd_b_lvl = tab_rd_b[lvl_q];

	// build covers nodes 1 to min(node_count, NODES-1)
	assign count_w  = lcal_pkg::wide_t'(node_count_q);
	assign last_w   = (count_w > lcal_pkg::wide_t'(lcal_pkg::NODES - 1)) ?
		lcal_pkg::wide_t'(lcal_pkg::NODES - 1) : count_w;
	assign last_idx = last_w[lcal_pkg::IDX_W-1:0];

	assign du   = node_ok ? dep_rd_a : '0;
	assign dv   = other_ok ? dep_rd_b : '0;
	assign swap = (dv < du);

	assign jump_a = lcal_pkg::is_node(u_q) ? rd_a_lvl : lcal_pkg::NONE_ID;
	assign jump_b = lcal_pkg::is_node(v_q) ? rd_b_lvl : lcal_pkg::NONE_ID;

	assign status.mode        = mode_q;
	assign status.clear_last  = (idx_q == lcal_pkg::IDX_LAST);
	assign status.build_empty = (last_idx == '0) || (lcal_pkg::LEVELS == 1);
	assign status.build_last  = (idx_q == last_idx) && (lvl_q == lcal_pkg::LVL_TOP);
	assign status.diff_zero   = (diff_q == '0);
	assign status.diff_bit    = diff_q[0];
	assign status.u_eq_v      = (u_q == v_q);
	assign status.lvl_zero    = (lvl_q == '0);
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid          = out_valid_q;
	assign out_ancestor       = out_ancestor_q;
	assign out_ancestor_valid = out_ancestor_valid_q;

	always_comb begin
		tab_we      = '0;
		tab_waddr   = idx_q;
		tab_wdata   = lcal_pkg::NONE_ID;
		tab_raddr_a = idx_q;
		tab_raddr_b = lcal_pkg::idx_of(v_q);
		dep_we      = 1'b0;
		dep_raddr_b = lcal_pkg::idx_of(other_id);
		unique case (op)
			lcal_pkg::OP_CLEAR: begin
				tab_we = '1;
			end
			lcal_pkg::OP_LOAD: begin
				tab_we[0] = node_ok;
				tab_waddr = node_idx;
				tab_wdata = parent_q;
				dep_we    = node_ok;
			end
			lcal_pkg::OP_BUILD_FOLLOW: begin
				tab_raddr_a = lcal_pkg::idx_of(rd_src);
			end
			lcal_pkg::OP_BUILD_WRITE: begin
				// absent ancestor: leave the entry as it is
				for (int i = 0; i < lcal_pkg::LEVELS; i++) begin
					tab_we[i] = (mid_q != lcal_pkg::NONE_ID) &&
						(lcal_pkg::lvl_t'(i) == lvl_q);
				end
				tab_wdata = lcal_pkg::is_node(mid_q) ? rd_src : lcal_pkg::NONE_ID;
			end
			lcal_pkg::OP_LIFT_STEP: begin
				tab_raddr_a = lcal_pkg::idx_of(v_q);
			end
			lcal_pkg::OP_JUMP_READ: begin
				tab_raddr_a = lcal_pkg::idx_of(u_q);
			end
			lcal_pkg::OP_PARENT_READ: begin
				tab_raddr_a = lcal_pkg::idx_of(u_q);
			end
			default: begin
			end
		endcase
	end

	for (genvar g = 0; g < lcal_pkg::LEVELS; g++) begin : g_bank
		lcal_ram #(
			.WIDTH (lcal_pkg::ID_W),
			.DEPTH (lcal_pkg::NODES)
		) u_tab_ram (
			.clk     (clk),
			.we      (tab_we[g]),
			.waddr   (tab_waddr),
			.wdata   (tab_wdata),
			.raddr_a (tab_raddr_a),
			.rdata_a (tab_rd_a[g]),
			.raddr_b (tab_raddr_b),
			.rdata_b (tab_rd_b[g])
		);
	end

	lcal_ram #(
		.WIDTH (lcal_pkg::DEPTH_W),
		.DEPTH (lcal_pkg::NODES)
	) u_depth_ram (
		.clk     (clk),
		.we      (dep_we),
		.waddr   (node_idx),
		.wdata   (depth_q),
		.raddr_a (node_idx),
		.rdata_a (dep_rd_a),
		.raddr_b (dep_raddr_b),
		.rdata_b (dep_rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= lcal_pkg::COUNT_RESET;
			idx_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (op == lcal_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (op)
				lcal_pkg::OP_CLEAR: begin
					idx_q <= idx_q + lcal_pkg::idx_t'(1);
				end
				lcal_pkg::OP_BUILD_INIT: begin
					idx_q <= lcal_pkg::idx_t'(1);
				end
				lcal_pkg::OP_BUILD_WRITE: begin
					idx_q <= (idx_q == last_idx) ? lcal_pkg::idx_t'(1) :
						idx_q + lcal_pkg::idx_t'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			lcal_pkg::OP_CAPTURE: begin
				mode_q   <= lcal_pkg::mode_t'(in_mode);
				node_q   <= in_node;
				other_q  <= in_other_node;
				parent_q <= in_parent_node;
				depth_q  <= in_depth_value;
			end
			lcal_pkg::OP_BUILD_INIT: begin
				lvl_q <= lcal_pkg::lvl_t'(1);
			end
			lcal_pkg::OP_BUILD_FOLLOW: begin
				mid_q <= rd_src;
			end
			lcal_pkg::OP_BUILD_WRITE: begin
				if (idx_q == last_idx) begin
					lvl_q <= lvl_q + lcal_pkg::lvl_t'(1);
				end
			end
			lcal_pkg::OP_ORDER: begin
				// keep the shallower node in u, lift v
				lvl_q  <= '0;
				u_q    <= swap ? other_id : node_id;
				v_q    <= swap ? node_id : other_id;
				diff_q <= (swap ? (du - dv) : (dv - du)) & lcal_pkg::DIFF_MASK;
			end
			lcal_pkg::OP_LIFT_STEP: begin
				if (!diff_q[0]) begin
					diff_q <= diff_q >> 1;
					lvl_q  <= lvl_q + lcal_pkg::lvl_t'(1);
				end
			end
			lcal_pkg::OP_LIFT_TAKE: begin
				v_q    <= lcal_pkg::is_node(v_q) ? rd_a_lvl : lcal_pkg::NONE_ID;
				diff_q <= diff_q >> 1;
				lvl_q  <= lvl_q + lcal_pkg::lvl_t'(1);
			end
			lcal_pkg::OP_JUMP_INIT: begin
				lvl_q <= lcal_pkg::LVL_TOP;
				res_q <= u_q;
			end
			lcal_pkg::OP_JUMP_TAKE: begin
				if (jump_a != jump_b) begin
					u_q <= jump_a;
					v_q <= jump_b;
				end
				lvl_q <= lvl_q - lcal_pkg::lvl_t'(1);
			end
			lcal_pkg::OP_PARENT_TAKE: begin
				res_q <= lcal_pkg::is_node(u_q) ? tab_rd_a[0] : lcal_pkg::NONE_ID;
			end
			lcal_pkg::OP_EMIT: begin
				out_ancestor_q       <= (mode_q == lcal_pkg::MODE_QUERY) ? res_q : '0;
				out_ancestor_valid_q <= (mode_q == lcal_pkg::MODE_QUERY);
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: sv/lowest_common_ancestor_lifting_unit.sv
// Top level of the binary lifting lowest common ancestor engine.
// Items arrive on in_ch and each produces exactly one result on out_ch; results
// are held in an output register, so the next item is taken while a result waits.
// Items are handled one at a time. After reset the ancestor table is swept to
// "no ancestor" before the first item is taken. A load writes the parent to
// level 0 and the depth to the depth memory. A query lifts the deeper node by
// each set bit of the depth difference and, unless the nodes then meet,
// searches the levels downward and reads the parent. A build fills levels 1
// to LEVELS-1 for nodes 1 to min(node_count, NODES-1). Each lift step is a
// dependent read of one table level whose registered read data is then taken.
// The user writes node_count through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this.
module lowest_common_ancestor_lifting_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  lcal_pkg::count_t cfg_wdata,
	lcal_in_if.sink          in_ch,
	lcal_out_if.source       out_ch
);

	lcal_pkg::dp_op_t     op;
	lcal_pkg::dp_status_t status;
	logic                 in_ready;
	logic                 out_valid;
	lcal_pkg::id_t        out_ancestor;
	logic                 out_ancestor_valid;

	lcal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.op       (op)
	);

	lcal_datapath u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.op                 (op),
		.status             (status),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.in_mode            (in_ch.mode),
		.in_node            (in_ch.node),
		.in_other_node      (in_ch.other_node),
		.in_parent_node     (in_ch.parent_node),
		.in_depth_value     (in_ch.depth_value),
		.out_valid          (out_valid),
		.out_ready          (out_ch.ready),
		.out_ancestor       (out_ancestor),
		.out_ancestor_valid (out_ancestor_valid)
	);

	assign in_ch.ready           = in_ready;
	assign out_ch.valid          = out_valid;
	assign out_ch.ancestor       = out_ancestor;
	assign out_ch.ancestor_valid = out_ancestor_valid;

endmodule
